// ===== rtl/core/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion converter.
`default_nettype none
package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC   = 14;
  localparam int ROOT_W = 16;
  localparam int NUM_W  = 17;
  localparam int REM_W  = 18;
  localparam int QUO_W  = 17;

  localparam logic signed [17:0] ONE = 18'sd16384;

  // branch select: trace or the diagonal that supplies the root
  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  typedef struct packed {
    logic [31:0]                n;
    logic [1:0]                 sel;
    logic [2:0][NUM_W-1:0]      mag;
    logic [2:0]                 neg;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0]          root;
    logic [1:0]                 sel;
    logic [2:0][NUM_W-1:0]      mag;
    logic [2:0]                 neg;
  } root_t;

  typedef struct packed {
    logic [ROOT_W-1:0]          root;
    logic [1:0]                 sel;
    logic [2:0]                 neg;
    logic [2:0][QUO_W-1:0]      q;
    logic [2:0]                 ovf;
  } quot_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage
`default_nettype wire

// ===== rtl/core/rmq_front.sv =====
// Front end: trace, branch pick, radicand and the three numerators.
`default_nettype none
module rmq_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [143:0]                 in_mat,
  output logic                              out_valid,
  output rmq_pkg::front_t                   out_item
);
  import rmq_pkg::*;

  logic        v1;
  logic [8:0][15:0] mat;
  logic [1:0]  sel;

  logic signed [17:0] t, e00, e11, e22;
  logic [1:0]  pick;

  always_comb begin
    e00 = 18'(signed'(in_mat[15:0]));
    e11 = 18'(signed'(in_mat[79:64]));
    e22 = 18'(signed'(in_mat[143:128]));
    t   = e00 + e11 + e22;
    pick = SEL_X;
    if (e11 > e00) pick = SEL_Y;
    if (e22 > ((pick == SEL_Y) ? e11 : e00)) pick = SEL_Z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      mat <= in_mat;
      sel <= (!t[17] && t != 18'sd0) ? SEL_TRACE : pick;
    end
  end

  // second stage
  function automatic logic signed [NUM_W-1:0] ext(input logic [15:0] v);
    ext = NUM_W'(signed'(v));
  endfunction

  logic signed [17:0] a, f00, f11, f22;
  logic signed [NUM_W-1:0] d [3];
  front_t nxt;

  always_comb begin
    f00 = 18'(signed'(mat[0]));
    f11 = 18'(signed'(mat[4]));
    f22 = 18'(signed'(mat[8]));
    case (sel)
      SEL_TRACE: begin
        a    = f00 + f11 + f22 + ONE;
        d[0] = ext(mat[7]) - ext(mat[5]);
        d[1] = ext(mat[2]) - ext(mat[6]);
        d[2] = ext(mat[3]) - ext(mat[1]);
      end
      SEL_X: begin
        a    = f00 - f11 - f22 + ONE;
        d[0] = ext(mat[7]) - ext(mat[5]);
        d[1] = ext(mat[3]) + ext(mat[1]);
        d[2] = ext(mat[6]) + ext(mat[2]);
      end
      SEL_Y: begin
        a    = f11 - f22 - f00 + ONE;
        d[0] = ext(mat[2]) - ext(mat[6]);
        d[1] = ext(mat[7]) + ext(mat[5]);
        d[2] = ext(mat[1]) + ext(mat[3]);
      end
      default: begin
        a    = f22 - f00 - f11 + ONE;
        d[0] = ext(mat[3]) - ext(mat[1]);
        d[1] = ext(mat[2]) + ext(mat[6]);
        d[2] = ext(mat[5]) + ext(mat[7]);
      end
    endcase
    nxt.sel = sel;
    // a non-positive radicand gives a zero root
    nxt.n = (!a[17] && a != 18'sd0) ? {1'b0, a[16:0], 14'b0} : 32'd0;
    for (int k = 0; k < 3; k++) begin
      nxt.neg[k] = d[k][NUM_W-1];
      nxt.mag[k] = d[k][NUM_W-1] ? (NUM_W'(0) - d[k]) : d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_item <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rmq_sqrt.sv =====
// Pipelined integer square root, two result bits per stage.
`default_nettype none
module rmq_sqrt (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire rmq_pkg::front_t   in_item,
  output logic                   out_valid,
  output rmq_pkg::root_t         out_item
);
  import rmq_pkg::*;

  localparam int STAGES = ROOT_W / 2;

  function automatic sq_t sq_step(input sq_t s, input logic [1:0] dig);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] tr;
    r2 = {s.rem[REM_W-3:0], dig};
    tr = {s.root, 2'b01};
    if (r2 >= tr) begin
      sq_step.rem  = r2 - tr;
      sq_step.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_step.rem  = r2;
      sq_step.root = {s.root[ROOT_W-2:0], 1'b0};
    end
  endfunction

  logic   v   [STAGES];
  sq_t    st  [STAGES];
  front_t itm [STAGES];

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_stage
      sq_t    prev, mid, fin;
      front_t pitm;
      logic   pv;
      if (g == 0) begin : g_first
        assign prev = '0;
        assign pitm = in_item;
        assign pv   = in_valid;
      end else begin : g_rest
        assign prev = st[g-1];
        assign pitm = itm[g-1];
        assign pv   = v[g-1];
      end
      assign mid = sq_step(prev, pitm.n[31-4*g -: 2]);
      assign fin = sq_step(mid,  pitm.n[29-4*g -: 2]);

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (en) begin
          v[g] <= pv;
        end
        if (en) begin
          st[g]  <= fin;
          itm[g] <= pitm;
        end
      end
    end
  endgenerate

  assign out_valid     = v[STAGES-1];
  assign out_item.root = st[STAGES-1].root;
  assign out_item.sel  = itm[STAGES-1].sel;
  assign out_item.mag  = itm[STAGES-1].mag;
  assign out_item.neg  = itm[STAGES-1].neg;

endmodule
`default_nettype wire

// ===== rtl/core/rmq_div.sv =====
// Three-lane pipelined restoring divider: mag * 2^14 / (2 * root).
`default_nettype none
module rmq_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire rmq_pkg::root_t    in_item,
  output logic                   out_valid,
  output rmq_pkg::quot_t         out_item
);
  import rmq_pkg::*;

  localparam int STAGES = 1 + (QUO_W - 1) / 2;

  typedef struct packed {
    logic [2:0][QUO_W-1:0] rem;
    logic [2:0][QUO_W-1:0] q;
    logic [2:0]            ovf;
  } ln_t;

  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [QUO_W-1:0] q;
  } dv_t;

  function automatic dv_t dstep(input dv_t s, input logic b, input logic [QUO_W-1:0] den);
    logic [QUO_W:0] t;
    t = {s.rem, b};
    if (t >= {1'b0, den}) begin
      dstep.rem = QUO_W'(t - {1'b0, den});
      dstep.q   = {s.q[QUO_W-2:0], 1'b1};
    end else begin
      dstep.rem = t[QUO_W-1:0];
      dstep.q   = {s.q[QUO_W-2:0], 1'b0};
    end
  endfunction

  logic  v   [STAGES];
  ln_t   ln  [STAGES];
  root_t itm [STAGES];

  // first stage: overflow check and the top quotient bit
  ln_t   ln0;
  logic [QUO_W-1:0] den0;
  always_comb begin
    den0 = {in_item.root, 1'b0};
    for (int k = 0; k < 3; k++) begin
      dv_t s0, s1;
      s0.rem = QUO_W'(in_item.mag[k] >> 3);
      s0.q   = '0;
      s1 = dstep(s0, in_item.mag[k][2], den0);
      ln0.rem[k] = s1.rem;
      ln0.q[k]   = s1.q;
      // quotient reaches 2^17 when mag >= 8 * den
      ln0.ovf[k] = {3'b000, in_item.mag[k]} >= {den0, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      ln[0]  <= ln0;
      itm[0] <= in_item;
    end
  end

  genvar g;
  generate
    for (g = 1; g < STAGES; g++) begin : g_stage
      ln_t nx;
      logic [QUO_W-1:0] den;
      // dividend bit positions handled here: hb and hb-1
      localparam int HB = QUO_W - 2*g;
      assign den = {itm[g-1].root, 1'b0};
      always_comb begin
        nx.ovf = ln[g-1].ovf;
        for (int k = 0; k < 3; k++) begin
          dv_t a0, a1, a2;
          logic b1, b2;
          b1 = (HB >= FRAC) ? itm[g-1].mag[k][(HB >= FRAC) ? HB - FRAC : 0] : 1'b0;
          b2 = (HB - 1 >= FRAC) ? itm[g-1].mag[k][(HB - 1 >= FRAC) ? HB - 1 - FRAC : 0]
                                : 1'b0;
          a0.rem = ln[g-1].rem[k];
          a0.q   = ln[g-1].q[k];
          a1 = dstep(a0, b1, den);
          a2 = dstep(a1, b2, den);
          nx.rem[k] = a2.rem;
          nx.q[k]   = a2.q;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (en) begin
          v[g] <= v[g-1];
        end
        if (en) begin
          ln[g]  <= nx;
          itm[g] <= itm[g-1];
        end
      end
    end
  endgenerate

  assign out_valid     = v[STAGES-1];
  assign out_item.root = itm[STAGES-1].root;
  assign out_item.sel  = itm[STAGES-1].sel;
  assign out_item.neg  = itm[STAGES-1].neg;
  assign out_item.q    = ln[STAGES-1].q;
  assign out_item.ovf  = ln[STAGES-1].ovf;

endmodule
`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion_top.sv =====
// Top level of the rotation matrix to quaternion converter.
`default_nettype none
// Converts one Q2.14 3x3 rotation matrix per item into a Q2.14 quaternion.
// Fully pipelined: one item per clock while no stall holds it; 2 front stages,
// 8 square-root stages at two root bits each, 9 divider stages with one
// quotient bit in the first and two in each of the rest, 1 output register.
// A stall on the result side holds the whole pipeline; s_tready falls only
// while a result waits unread.
// tuser on the result marks a zero square root, with the quaternion forced
// to zero.
module rotation_matrix_to_quaternion_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, low first)
  input  wire logic [143:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // qw, qx, qy, qz (16 bits each, low first)
  output logic [63:0]       m_tdata,
  // degenerate
  output logic              m_tuser
);
  import rmq_pkg::*;

  logic   en;
  logic   fv, rv, qv;
  front_t fitm;
  root_t  ritm;
  quot_t  qitm;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rmq_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_mat(s_tdata),
    .out_valid(fv), .out_item(fitm)
  );

  rmq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fv), .in_item(fitm),
    .out_valid(rv), .out_item(ritm)
  );

  rmq_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(rv), .in_item(ritm),
    .out_valid(qv), .out_item(qitm)
  );

  function automatic logic [15:0] sat(input logic [QUO_W-1:0] q, input logic ovf,
                                      input logic neg);
    if (!neg) begin
      sat = (ovf || q > QUO_W'(32767)) ? 16'h7fff : q[15:0];
    end else begin
      sat = (ovf || q > QUO_W'(32768)) ? 16'h8000 : (16'd0 - q[15:0]);
    end
  endfunction

  logic [15:0] half, d0, d1, d2;
  logic [15:0] w, x, y, z;
  logic        degen;

  always_comb begin
    half  = {1'b0, qitm.root[ROOT_W-1:1]};
    d0    = sat(qitm.q[0], qitm.ovf[0], qitm.neg[0]);
    d1    = sat(qitm.q[1], qitm.ovf[1], qitm.neg[1]);
    d2    = sat(qitm.q[2], qitm.ovf[2], qitm.neg[2]);
    degen = (qitm.root == '0);
    case (qitm.sel)
      SEL_TRACE: begin w = half; x = d0;   y = d1;   z = d2;   end
      SEL_X:     begin w = d0;   x = half; y = d1;   z = d2;   end
      SEL_Y:     begin w = d0;   x = d2;   y = half; z = d1;   end
      default:   begin w = d0;   x = d1;   y = d2;   z = half; end
    endcase
    if (degen) begin
      w = '0; x = '0; y = '0; z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= qv;
    end
    if (en) begin
      m_tdata <= {z, y, x, w};
      m_tuser <= degen;
    end
  end

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 64'd0)
    else $error("degenerate result carries nonzero quaternion");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result is stalled");

  a_no_result_from_idle : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !qv |=> !m_tvalid)
    else $error("result appeared without a pipeline item");

endmodule
`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_top_test.sv =====
// Testbench for the rotation matrix to quaternion converter: directed and random matrices.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top_test;
  import rmq_pkg::*;

  typedef struct {
    logic [15:0] qw, qx, qy, qz;
    logic        degen;
  } quat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  quat_t quat_q[$];
  int    err_cnt = 0;
  bit    rx_stall_on = 1'b1;

  rotation_matrix_to_quaternion_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // num * 2^FRAC / den, truncated toward zero
  function automatic longint frac_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag << FRAC) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic quat_t matrix_to_quat(logic [143:0] d);
    longint m[3][3];
    longint q[4];
    longint t, a, r, den, one;
    int i, j, k;
    quat_t res;
    one = 1 << FRAC;
    for (int e = 0; e < 9; e++) m[e / 3][e % 3] = longint'($signed(d[e*16 +: 16]));
    for (int e = 0; e < 4; e++) q[e] = 0;
    r = 0;
    t = m[0][0] + m[1][1] + m[2][2];
    if (t > 0) begin
      a = t + one;
      r = int_sqrt(a << FRAC);
      den = r << 1;
      q[0] = r >> 1;
      q[1] = frac_div(m[2][1] - m[1][2], den);
      q[2] = frac_div(m[0][2] - m[2][0], den);
      q[3] = frac_div(m[1][0] - m[0][1], den);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = m[i][i] - m[j][j] - m[k][k] + one;
      if (a > 0) r = int_sqrt(a << FRAC);
      if (r != 0) begin
        den = r << 1;
        q[1 + i] = r >> 1;
        q[0] = frac_div(m[k][j] - m[j][k], den);
        q[1 + j] = frac_div(m[j][i] + m[i][j], den);
        q[1 + k] = frac_div(m[k][i] + m[i][k], den);
      end
    end
    res.qw = clamp16(q[0]);
    res.qx = clamp16(q[1]);
    res.qy = clamp16(q[2]);
    res.qz = clamp16(q[3]);
    res.degen = (r == 0);
    return res;
  endfunction

  // valid stays up between back-to-back items; it drops only for a gap
  task automatic send_matrix(logic [143:0] d);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    quat_q.push_back(matrix_to_quat(d));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [143:0] pack_mat(int e0, int e1, int e2, int e3, int e4,
                                             int e5, int e6, int e7, int e8);
    return {e8[15:0], e7[15:0], e6[15:0], e5[15:0], e4[15:0],
            e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
  endfunction

  // receiver: random wait before each item while rx_stall_on is set, compares each result
  initial begin
    quat_t exp_q;
    logic [63:0] act;
    int wait_n;
    @(negedge rst);
    forever begin
      wait_n = rx_stall_on ? $urandom_range(0, 14) : 0;
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      act = m_tdata;
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, act, m_tuser);
        err_cnt++;
      end else begin
        exp_q = quat_q.pop_front();
        if (act !== {exp_q.qz, exp_q.qy, exp_q.qx, exp_q.qw} || m_tuser !== exp_q.degen) begin
          $display("%0t: mismatch exp %h %h %h %h deg %b, got %h %h %h %h deg %b", $time,
                   exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.degen,
                   act[15:0], act[31:16], act[47:32], act[63:48], m_tuser);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_identity_and_rotations();
    send_matrix(pack_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_matrix(pack_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    send_matrix(pack_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    send_matrix(pack_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    send_matrix(pack_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    send_matrix(pack_mat(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
  endtask

  task automatic test_special_cases();
    // diagonal ties keep the lower index
    send_matrix(pack_mat(-5000, 100, 200, 300, -5000, 400, 500, 600, -5000));
    send_matrix(pack_mat(-9000, 1, 2, 3, 4000, 5, 6, 7, 4000));
    send_matrix(pack_mat(0, 1000, -1000, 2000, 0, 3000, -3000, 4000, 0));
    // zero and negative diagonals
    send_matrix(pack_mat(-16384, 7, 7, 7, 0, 7, 7, 7, 0));
    send_matrix(pack_mat(-32768, 5, 5, 5, -32768, 5, 5, 5, -32768));
    send_matrix(pack_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // extremes and saturation
    send_matrix(pack_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(pack_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                         -32768));
    send_matrix(pack_mat(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
    send_matrix(pack_mat(-32768, 32767, 32767, 32767, 32767, -32768, 32767, -32768, 0));
    send_matrix(pack_mat(-16000, 32767, 32767, 32767, 16000, -32768, 32767, -32768, 1));
    send_matrix(pack_mat(1, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (quat_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_random(int count);
    logic [143:0] d;
    int s, ang;
    for (int n = 0; n < count; n++) begin
      d = {16'($urandom), $urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 3))
        0: ; // fully random
        1: begin
          // near-rotation: dominant diagonal, small off-diagonals
          for (int e = 0; e < 9; e++) begin
            s = $urandom_range(0, 4000) - 2000;
            if (e % 4 == 0)
              s = (($urandom_range(0, 1)) ? 16384 : -16384) + s;
            d[e*16 +: 16] = s[15:0];
          end
        end
        2: begin
          for (int e = 0; e < 9; e++) begin
            ang = $urandom_range(0, 32768) - 16384;
            d[e*16 +: 16] = ang[15:0];
          end
        end
        default: begin
          // small magnitudes hit diagonal ties
          for (int e = 0; e < 9; e++) begin
            s = $urandom_range(0, 64) - 32;
            d[e*16 +: 16] = s[15:0];
          end
        end
      endcase
      send_matrix(d);
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_identity_and_rotations();
    test_special_cases();
    wait_drained();
    test_random(900);
    rx_stall_on = 1'b0;
    test_random(100);
    rx_stall_on = 1'b1;
    test_random(750);
    wait_drained();
    repeat (30) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
